@@ hw/rtl/stc_pkg.sv @@
// Shared region codes for the sphere-triangle closest-point core.
package stc_pkg;

  localparam logic [2:0] REG_A    = 3'd0;
  localparam logic [2:0] REG_B    = 3'd1;
  localparam logic [2:0] REG_C    = 3'd2;
  localparam logic [2:0] REG_AB   = 3'd3;
  localparam logic [2:0] REG_BC   = 3'd4;
  localparam logic [2:0] REG_CA   = 3'd5;
  localparam logic [2:0] REG_FACE = 3'd6;

endpackage

@@ hw/rtl/sphere_triangle_closest_point_core.sv @@
// Sphere-triangle closest point core, fully pipelined.
// Throughput: one request per cycle while the output is not stalled.
// The floor divider retires one quotient bit per stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and sets the radius to 1.0.
module sphere_triangle_closest_point_core
  import stc_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // centre_x,y,z, vert_a_x,y,z, vert_b_x,y,z, vert_c_x,y,z, zero pad
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // near_x, near_y, near_z, zero pad
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  // region[2:0], hit[3]
  output logic [3:0]                             m_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [COORD_BITS-2:0]                  cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int RW   = CW - 1;
  localparam int DFW  = CW + 1;
  localparam int PW   = 2 * DFW;
  localparam int DTW  = PW + 2;
  localparam int CRW  = PW + 1;
  localparam int TPW  = 2 * CRW + 2;
  localparam int WW   = TPW + 2;
  localparam int NSW  = WW + DFW + 2;
  localparam int NW   = NSW + 2;
  localparam int QB   = CW + 2;
  localparam int SW   = QB + 3;
  localparam int SDN  = QB + 7;
  localparam int LAT  = QB + 20;
  localparam int ODW  = ((3*CW+7)/8)*8;

  typedef struct packed {
    logic [2:0][CW-1:0]  p;
    logic [2:0][CW-1:0]  a;
    logic [2:0][CW-1:0]  b;
    logic [2:0][CW-1:0]  c;
    logic [2:0][DFW-1:0] ab;
    logic [2:0][DFW-1:0] ac;
    logic [2:0][DFW-1:0] bc;
  } geo_t;

  typedef struct packed {
    logic [2:0]         region;
    logic [2:0][CW-1:0] base;
    logic [2:0][CW-1:0] p;
  } side_t;

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][QB-1:0] q;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [WW-1:0]      dv;
  } div_t;

  typedef struct packed {
    logic [2:0]         region;
    logic [2:0][CW-1:0] near;
  } res_t;

  function automatic logic signed [DFW-1:0] dif(logic [CW-1:0] x, logic [CW-1:0] y);
    return DFW'($signed(x)) - DFW'($signed(y));
  endfunction

  logic           en;
  logic [LAT-1:0] vld;
  logic [RW-1:0]  radius;
  logic [2*RW-1:0] rr;

  assign en        = !vld[LAT-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      radius <= RW'(1) << FRAC_BITS;
    end else begin
      if (en) vld <= {vld[LAT-2:0], s_tvalid};
      if (cfg_valid) radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rr <= radius * radius;
  end

  // capture and difference stages
  geo_t geo [8];
  logic signed [DFW-1:0] pa1 [3];
  logic signed [DFW-1:0] pb1 [3];
  logic signed [DFW-1:0] pc1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        geo[0].p[k]  <= s_tdata[k*CW +: CW];
        geo[0].a[k]  <= s_tdata[(3+k)*CW +: CW];
        geo[0].b[k]  <= s_tdata[(6+k)*CW +: CW];
        geo[0].c[k]  <= s_tdata[(9+k)*CW +: CW];
      end
      geo[0].ab <= '0;
      geo[0].ac <= '0;
      geo[0].bc <= '0;
      geo[1].p  <= geo[0].p;
      geo[1].a  <= geo[0].a;
      geo[1].b  <= geo[0].b;
      geo[1].c  <= geo[0].c;
      for (int k = 0; k < 3; k++) begin
        geo[1].ab[k] <= dif(geo[0].b[k], geo[0].a[k]);
        geo[1].ac[k] <= dif(geo[0].c[k], geo[0].a[k]);
        geo[1].bc[k] <= dif(geo[0].c[k], geo[0].b[k]);
        pa1[k] <= dif(geo[0].p[k], geo[0].a[k]);
        pb1[k] <= dif(geo[0].p[k], geo[0].b[k]);
        pc1[k] <= dif(geo[0].p[k], geo[0].c[k]);
      end
      for (int i = 2; i < 8; i++) geo[i] <= geo[i-1];
    end
  end

  // first products: six dot products and four cross products
  logic signed [DFW-1:0] op1a [42];
  logic signed [DFW-1:0] op1b [42];
  logic signed [PW-1:0]  pr1  [42];
  logic signed [DFW-1:0] cu   [4][3];
  logic signed [DFW-1:0] cv   [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op1a[k]    = pa1[k]; op1b[k]    = $signed(geo[1].ab[k]);
      op1a[3+k]  = pb1[k]; op1b[3+k]  = $signed(geo[1].ab[k]);
      op1a[6+k]  = pa1[k]; op1b[6+k]  = $signed(geo[1].ac[k]);
      op1a[9+k]  = pc1[k]; op1b[9+k]  = $signed(geo[1].ac[k]);
      op1a[12+k] = pb1[k]; op1b[12+k] = $signed(geo[1].bc[k]);
      op1a[15+k] = pc1[k]; op1b[15+k] = $signed(geo[1].bc[k]);
      cu[0][k] = $signed(geo[1].ab[k]); cv[0][k] = $signed(geo[1].ac[k]);
      cu[1][k] = pa1[k];                cv[1][k] = pb1[k];
      cu[2][k] = pb1[k];                cv[2][k] = pc1[k];
      cu[3][k] = pc1[k];                cv[3][k] = pa1[k];
    end
    for (int q = 0; q < 4; q++) begin
      op1a[18+q*6]   = cu[q][1]; op1b[18+q*6]   = cv[q][2];
      op1a[18+q*6+1] = cu[q][2]; op1b[18+q*6+1] = cv[q][1];
      op1a[18+q*6+2] = cu[q][2]; op1b[18+q*6+2] = cv[q][0];
      op1a[18+q*6+3] = cu[q][0]; op1b[18+q*6+3] = cv[q][2];
      op1a[18+q*6+4] = cu[q][0]; op1b[18+q*6+4] = cv[q][1];
      op1a[18+q*6+5] = cu[q][1]; op1b[18+q*6+5] = cv[q][0];
    end
  end

  for (genvar g = 0; g < 42; g++) begin : g_mul1
    stc_mul #(.WA(DFW), .WB(DFW)) u_mul (
      .clk(clk), .en(en), .a(op1a[g]), .b(op1b[g]), .p(pr1[g])
    );
  end

  logic signed [DTW-1:0] dt4 [6];
  logic signed [DTW-1:0] dt5 [6];
  logic signed [DTW-1:0] dt6 [6];
  logic signed [DTW-1:0] dt7 [6];
  logic signed [CRW-1:0] cr4 [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        if (j % 2 == 1)
          dt4[j] <= -(DTW'(pr1[j*3]) + DTW'(pr1[j*3+1]) + DTW'(pr1[j*3+2]));
        else
          dt4[j] <= DTW'(pr1[j*3]) + DTW'(pr1[j*3+1]) + DTW'(pr1[j*3+2]);
      end
      for (int q = 0; q < 4; q++)
        for (int k = 0; k < 3; k++)
          cr4[q][k] <= CRW'(pr1[18+q*6+2*k]) - CRW'(pr1[18+q*6+2*k+1]);
      dt5 <= dt4;
      dt6 <= dt5;
      dt7 <= dt6;
    end
  end

  // triple products: vc, va, vb
  logic signed [2*CRW-1:0] pr2 [9];
  logic signed [TPW-1:0]   vw7 [3];

  for (genvar t = 0; t < 3; t++) begin : g_mul2t
    for (genvar k = 0; k < 3; k++) begin : g_mul2k
      stc_mul #(.WA(CRW), .WB(CRW)) u_mul (
        .clk(clk), .en(en), .a(cr4[0][k]), .b(cr4[t+1][k]), .p(pr2[t*3+k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++)
        vw7[t] <= TPW'(pr2[t*3]) + TPW'(pr2[t*3+1]) + TPW'(pr2[t*3+2]);
    end
  end

  // region decision
  logic signed [WW-1:0]    fsum;
  logic signed [DTW:0]     tot_ab;
  logic signed [DTW:0]     tot_bc;
  logic signed [DTW:0]     tot_ca;
  logic [2:0]              rg_n;
  logic [2:0][CW-1:0]      bs_n;
  logic signed [WW-1:0]    wt_n [3];
  logic signed [DFW-1:0]   vm_n [3][3];
  logic signed [WW-1:0]    dv_n;

  always_comb begin
    fsum   = WW'(vw7[0]) + WW'(vw7[1]) + WW'(vw7[2]);
    tot_ab = (DTW+1)'(dt7[0]) + (DTW+1)'(dt7[1]);
    tot_ca = (DTW+1)'(dt7[2]) + (DTW+1)'(dt7[3]);
    tot_bc = (DTW+1)'(dt7[4]) + (DTW+1)'(dt7[5]);
    rg_n   = REG_FACE;
    bs_n   = geo[7].c;
    dv_n   = WW'(1);
    for (int m = 0; m < 3; m++) begin
      wt_n[m] = '0;
      for (int k = 0; k < 3; k++) vm_n[m][k] = '0;
    end
    if (dt7[0] <= 0 && dt7[2] <= 0) begin
      rg_n = REG_A;
      bs_n = geo[7].a;
    end else if (dt7[1] <= 0 && dt7[4] <= 0) begin
      rg_n = REG_B;
      bs_n = geo[7].b;
    end else if (dt7[3] <= 0 && dt7[5] <= 0) begin
      rg_n = REG_C;
      bs_n = geo[7].c;
    end else if (vw7[0] <= 0 && dt7[0] >= 0 && dt7[1] >= 0) begin
      rg_n = REG_AB;
      bs_n = geo[7].a;
      if (tot_ab != 0) begin
        wt_n[0] = WW'(dt7[0]);
        dv_n    = WW'(tot_ab);
        for (int k = 0; k < 3; k++) vm_n[0][k] = $signed(geo[7].ab[k]);
      end
    end else if (vw7[1] <= 0 && dt7[4] >= 0 && dt7[5] >= 0) begin
      rg_n = REG_BC;
      bs_n = geo[7].b;
      if (tot_bc != 0) begin
        wt_n[0] = WW'(dt7[4]);
        dv_n    = WW'(tot_bc);
        for (int k = 0; k < 3; k++) vm_n[0][k] = $signed(geo[7].bc[k]);
      end
    end else if (vw7[2] <= 0 && dt7[2] >= 0 && dt7[3] >= 0) begin
      rg_n = REG_CA;
      bs_n = geo[7].a;
      if (tot_ca != 0) begin
        wt_n[0] = WW'(dt7[2]);
        dv_n    = WW'(tot_ca);
        for (int k = 0; k < 3; k++) vm_n[0][k] = $signed(geo[7].ac[k]);
      end
    end else if (fsum != 0) begin
      bs_n    = '0;
      wt_n[0] = WW'(vw7[1]);
      wt_n[1] = WW'(vw7[2]);
      wt_n[2] = WW'(vw7[0]);
      dv_n    = fsum;
      for (int k = 0; k < 3; k++) begin
        vm_n[0][k] = DFW'($signed(geo[7].a[k]));
        vm_n[1][k] = DFW'($signed(geo[7].b[k]));
        vm_n[2][k] = DFW'($signed(geo[7].c[k]));
      end
    end
  end

  side_t                 sd   [SDN];
  logic signed [WW-1:0]  wt8  [3];
  logic signed [DFW-1:0] vm8  [3][3];
  logic signed [WW-1:0]  dv8;
  logic signed [WW-1:0]  dv9;
  logic signed [WW-1:0]  dv10;
  logic signed [WW-1:0]  dv11;

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].region <= rg_n;
      sd[0].base   <= bs_n;
      sd[0].p      <= geo[7].p;
      for (int i = 1; i < SDN; i++) sd[i] <= sd[i-1];
      wt8  <= wt_n;
      vm8  <= vm_n;
      dv8  <= dv_n;
      dv9  <= dv8;
      dv10 <= dv9;
      dv11 <= dv10;
    end
  end

  // weighted numerators
  logic signed [WW+DFW-1:0] pr3 [9];

  for (genvar m = 0; m < 3; m++) begin : g_mul3m
    for (genvar k = 0; k < 3; k++) begin : g_mul3k
      stc_mul #(.WA(WW), .WB(DFW)) u_mul (
        .clk(clk), .en(en), .a(wt8[m]), .b(vm8[m][k]), .p(pr3[m*3+k])
      );
    end
  end

  logic signed [NSW-1:0] num11 [3];
  logic signed [NSW:0]   n12   [3];
  logic [WW-1:0]         dpos12;
  logic [WW-1:0]         dpos13;
  logic [2:0]            neg13;
  logic [NW-1:0]         np13  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        num11[k] <= NSW'(pr3[k]) + NSW'(pr3[3+k]) + NSW'(pr3[6+k]);
      dpos12 <= dv11[WW-1] ? WW'(-dv11) : WW'(dv11);
      for (int k = 0; k < 3; k++)
        n12[k] <= dv11[WW-1] ? -((NSW+1)'(num11[k])) : (NSW+1)'(num11[k]);
      dpos13 <= dpos12;
      for (int k = 0; k < 3; k++) begin
        neg13[k] <= n12[k][NSW];
        np13[k]  <= n12[k][NSW] ? NW'(-n12[k]) + NW'(dpos12) - NW'(1) : NW'(n12[k]);
      end
    end
  end

  // restoring floor divider, one quotient bit per stage
  div_t          ds   [QB+1];
  logic [NW-1:0] dsub [QB+1];

  assign dsub[0] = NW'(dpos13) << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].dv  <= dpos13;
      ds[0].neg <= neg13;
      ds[0].q   <= '0;
      for (int k = 0; k < 3; k++) begin
        ds[0].rem[k] <= np13[k];
        ds[0].ovf[k] <= np13[k] >= dsub[0];
      end
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_div
    assign dsub[i] = NW'(ds[i-1].dv) << (QB - i);
    always_ff @(posedge clk) begin
      if (en) begin
        ds[i].dv  <= ds[i-1].dv;
        ds[i].neg <= ds[i-1].neg;
        ds[i].ovf <= ds[i-1].ovf;
        for (int k = 0; k < 3; k++) begin
          if (ds[i-1].rem[k] >= dsub[i]) begin
            ds[i].rem[k] <= ds[i-1].rem[k] - dsub[i];
            ds[i].q[k]   <= ds[i-1].q[k] | (QB'(1) << (QB - i));
          end else begin
            ds[i].rem[k] <= ds[i-1].rem[k];
            ds[i].q[k]   <= ds[i-1].q[k];
          end
        end
      end
    end
  end

  // apply sign, saturate, add base and clamp
  logic [QB:0]            qm  [3];
  logic signed [QB+1:0]   qs  [3];
  logic signed [SW-1:0]   sm  [3];
  logic [2:0][CW-1:0]     nr_n;
  logic signed [SW-1:0]   c_hi;
  logic signed [SW-1:0]   c_lo;

  assign c_hi = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  assign c_lo = $signed({{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qm[k] = ds[QB].ovf[k] ? {1'b1, {QB{1'b0}}} : {1'b0, ds[QB].q[k]};
      qs[k] = ds[QB].neg[k] ? -$signed({1'b0, qm[k]}) : $signed({1'b0, qm[k]});
      sm[k] = SW'($signed(sd[SDN-1].base[k])) + SW'(qs[k]);
      if (sm[k] > c_hi)      nr_n[k] = c_hi[CW-1:0];
      else if (sm[k] < c_lo) nr_n[k] = c_lo[CW-1:0];
      else                   nr_n[k] = sm[k][CW-1:0];
    end
  end

  res_t                  rs [4];
  logic [2:0][CW-1:0]    pf;
  logic signed [DFW-1:0] dn [3];
  logic signed [PW-1:0]  sq [3];
  logic [PW+1:0]         hsum;
  logic [ODW-1:0]        out_data;
  logic [3:0]            out_user;

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0].near   <= nr_n;
      rs[0].region <= sd[SDN-1].region;
      pf           <= sd[SDN-1].p;
      for (int k = 0; k < 3; k++) dn[k] <= dif(rs[0].near[k], pf[k]);
      for (int i = 1; i < 4; i++) rs[i] <= rs[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mul4
    stc_mul #(.WA(DFW), .WB(DFW)) u_mul (
      .clk(clk), .en(en), .a(dn[k]), .b(dn[k]), .p(sq[k])
    );
  end

  assign hsum = (PW+2)'(sq[0][PW-1:0]) + (PW+2)'(sq[1][PW-1:0]) + (PW+2)'(sq[2][PW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_data    <= ODW'(rs[3].near);
      out_user    <= {hsum <= (PW+2)'(rr), rs[3].region};
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_user;

`ifndef SYNTHESIS
  a_region_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:0] <= REG_FACE)
    else $error("region code out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline occupancy changed during stall");
`endif

endmodule

@@ hw/rtl/stc_mul.sv @@
// Two-stage signed multiplier built from partial products of at most 35 by 35 bits.
module stc_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int L   = 34;
  localparam int NA  = (WA + L - 1) / L;
  localparam int NB  = (WB + L - 1) / L;
  localparam int PWD = WA + WB;

  logic signed [NA*L-1:0] ax;
  logic signed [NB*L-1:0] bx;
  logic signed [2*L+1:0]  pp [NA][NB];
  logic signed [PWD-1:0]  acc;

  assign ax = (NA*L)'(a);
  assign bx = (NB*L)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= $signed({(i == NA-1) ? ax[i*L+L-1] : 1'b0, ax[i*L +: L]}) *
                      $signed({(j == NB-1) ? bx[j*L+L-1] : 1'b0, bx[j*L +: L]});
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PWD'(pp[i][j]) <<< (L * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule
